>>> design/bbc_pkg.sv
// Shared types and codes of the LRU buffer cache tag manager.
`timescale 1ns / 1ps
package bbc_pkg;

    localparam logic [2:0] OP_ACQUIRE    = 3'd0;
    localparam logic [2:0] OP_MARK_DIRTY = 3'd1;
    localparam logic [2:0] OP_RELEASE    = 3'd2;
    localparam logic [2:0] OP_FILL_DONE  = 3'd3;
    localparam logic [2:0] OP_FLUSH_CHK  = 3'd4;
    localparam logic [2:0] OP_FLUSH_DONE = 3'd5;

    localparam logic [2:0] ST_HIT    = 3'd0;
    localparam logic [2:0] ST_MISS   = 3'd1;
    localparam logic [2:0] ST_BUSY   = 3'd2;
    localparam logic [2:0] ST_NOFREE = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    localparam logic [7:0] CNT_MAX = 8'hFF;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SCAN, S_WALK, S_IDX, S_MOVE,
        S_MA_RD, S_MA_WR, S_MB_RD, S_MB_WR, S_MC_RD, S_MC_WR, S_WX, S_OUT
    } t_state;

    typedef struct packed {
        logic [15:0] dev;
        logic [31:0] blk;
        logic        present;
        logic        busy;
        logic        dirty;
        logic [7:0]  cnt;
    } t_meta;

    typedef struct packed {
        logic [31:0] vblk;
        logic [15:0] vdev;
        logic        wb;
        logic [7:0]  gidx;
        logic [2:0]  status;
    } t_res;

endpackage

>>> design/bbc_mem.sv
// Single-port-write, single-port-read buffer record memory with registered read.
`timescale 1ns / 1ps
module bbc_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 75
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

>>> design/block_buffer_cache_lru.sv
// Top level of the LRU buffer cache tag manager: sequencer around the record memory.
// After reset a clearing pass over every buffer initializes the record memory, during
// which no transaction is accepted. One item is handled at a time, all buffer records
// living in one record memory with one read and one write port. An acquire scans the
// pool one buffer per cycle until the first tag match, on a miss walks the recency chain
// from the tail one buffer per cycle, and on a hit or a miss relinks the buffer to the
// head by read-modify-write of its neighbours and of the old head; per-buffer operations
// read, modify and write back the record, and a release that frees the buffer relinks it.
// The result sits in an output register, so it may wait while the next item is accepted.
`timescale 1ns / 1ps
module block_buffer_cache_lru #(
    parameter int POOL_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // operation[2:0], device_id[18:3], block_number[50:19], buffer_index[58:51],
    // io_ok[59], zero[63:60]
    input  logic [63:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status[2:0], granted_index[10:3], evict_writeback[11], victim_device[27:12],
    // victim_block[59:28], zero[63:60]
    output logic [63:0] o_m_tdata
);
    import bbc_pkg::*;

    localparam int IW = $clog2(POOL_SIZE);
    localparam logic [IW-1:0] LAST = IW'(POOL_SIZE - 1);

    typedef struct packed {
        t_meta         meta;
        logic [IW-1:0] nxt;
        logic [IW-1:0] prv;
    } t_rec;
    localparam int RW = $bits(t_rec);

    t_state r_state, n_state;
    logic [2:0]    r_op, n_op;
    logic          r_ok, n_ok;
    logic [15:0]   r_dev, n_dev;
    logic [31:0]   r_blk, n_blk;
    logic [IW-1:0] r_ci, n_ci, r_v, n_v, r_xi, n_xi, r_head, n_head, r_tail, n_tail;
    t_rec          r_x, n_x;
    logic          r_move, n_move;
    t_res          r_res, n_res, r_out, n_out;
    logic          r_ovalid, n_ovalid;

    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    t_rec          mem_wdata, q;
    logic [RW-1:0] mem_q;

    bbc_mem #(.DEPTH(POOL_SIZE), .WIDTH(RW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );
    assign q = t_rec'(mem_q);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'd0, r_out};

    logic in_fire;
    assign in_fire = i_s_tvalid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state; n_op = r_op; n_ok = r_ok; n_dev = r_dev; n_blk = r_blk;
        n_ci = r_ci; n_v = r_v; n_xi = r_xi; n_head = r_head; n_tail = r_tail;
        n_x = r_x; n_move = r_move; n_res = r_res; n_out = r_out; n_ovalid = r_ovalid;
        mem_we = 1'b0; mem_waddr = r_xi; mem_wdata = r_x;
        mem_re = 1'b0; mem_raddr = r_xi;
        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_waddr = r_ci;
                mem_wdata = '0;
                mem_wdata.nxt = (r_ci == '0) ? '0 : r_ci - 1'b1;
                mem_wdata.prv = (r_ci == LAST) ? r_ci : r_ci + 1'b1;
                n_ci = r_ci + 1'b1;
                if (r_ci == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_op  = i_s_tdata[2:0];
                    n_dev = i_s_tdata[18:3];
                    n_blk = i_s_tdata[50:19];
                    n_ok  = i_s_tdata[59];
                    n_move = 1'b0;
                    n_res = '0;
                    n_res.status = ST_DONE;
                    n_res.gidx = i_s_tdata[58:51];
                    if (i_s_tdata[2:0] == OP_ACQUIRE) begin
                        mem_re = 1'b1;
                        mem_raddr = '0;
                        n_ci = '0;
                        n_state = S_SCAN;
                    end else if (i_s_tdata[2:0] <= OP_FLUSH_DONE
                                 && 32'(i_s_tdata[58:51]) < POOL_SIZE) begin
                        mem_re = 1'b1;
                        mem_raddr = IW'(i_s_tdata[58:51]);
                        n_xi = IW'(i_s_tdata[58:51]);
                        n_state = S_IDX;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                if (q.meta.present && q.meta.dev == r_dev && q.meta.blk == r_blk) begin
                    n_x = q;
                    n_xi = r_ci;
                    n_res.gidx = 8'(r_ci);
                    if (q.meta.busy) begin
                        n_res.status = ST_BUSY;
                        n_state = S_OUT;
                    end else begin
                        n_res.status = ST_HIT;
                        n_x.meta.busy = 1'b1;
                        if (q.meta.cnt != CNT_MAX) begin
                            n_x.meta.cnt = q.meta.cnt + 8'd1;
                        end
                        n_move = 1'b1;
                        n_state = S_MOVE;
                    end
                end else if (r_ci == LAST) begin
                    mem_re = 1'b1;
                    mem_raddr = r_tail;
                    n_v = r_tail;
                    n_state = S_WALK;
                end else begin
                    mem_re = 1'b1;
                    mem_raddr = r_ci + 1'b1;
                    n_ci = r_ci + 1'b1;
                end
            end
            S_WALK: begin
                if (!q.meta.busy) begin
                    n_res.status = ST_MISS;
                    n_res.gidx = 8'(r_v);
                    n_res.wb = q.meta.dirty;
                    n_res.vdev = q.meta.dev;
                    n_res.vblk = q.meta.blk;
                    n_x = q;
                    n_x.meta.dev = r_dev;
                    n_x.meta.blk = r_blk;
                    n_x.meta.present = 1'b1;
                    n_x.meta.busy = 1'b1;
                    n_x.meta.dirty = 1'b0;
                    n_x.meta.cnt = 8'd1;
                    n_xi = r_v;
                    n_move = 1'b1;
                    n_state = S_MOVE;
                end else if (r_v == r_head) begin
                    n_res.status = ST_NOFREE;
                    n_res.gidx = 8'd0;
                    n_state = S_OUT;
                end else begin
                    // step toward the more recent end
                    mem_re = 1'b1;
                    mem_raddr = q.prv;
                    n_v = q.prv;
                end
            end
            S_IDX: begin
                n_x = q;
                n_state = S_WX;
                case (r_op)
                    OP_MARK_DIRTY: n_x.meta.dirty = 1'b1;
                    OP_RELEASE: begin
                        if (q.meta.cnt != 8'd0) begin
                            n_x.meta.cnt = q.meta.cnt - 8'd1;
                        end
                        if (q.meta.cnt <= 8'd1) begin
                            n_x.meta.busy = 1'b0;
                            n_move = 1'b1;
                            n_state = S_MOVE;
                        end
                    end
                    OP_FILL_DONE: begin
                        if (!r_ok) begin
                            n_x.meta.busy = 1'b0;
                            n_x.meta.cnt = 8'd0;
                            n_x.meta.present = 1'b0;
                        end
                    end
                    OP_FLUSH_CHK: begin
                        if (q.meta.dirty && !q.meta.busy) begin
                            n_x.meta.busy = 1'b1;
                            n_res.status = ST_FLUSH;
                            n_res.vdev = q.meta.dev;
                            n_res.vblk = q.meta.blk;
                        end
                    end
                    default: begin
                        if (r_ok) begin
                            n_x.meta.dirty = 1'b0;
                        end
                        n_x.meta.busy = 1'b0;
                    end
                endcase
            end
            S_MOVE: begin
                n_state = (r_move && r_xi != r_head) ? S_MA_RD : S_WX;
            end
            S_MA_RD: begin
                mem_re = 1'b1;
                mem_raddr = r_x.prv;
                n_state = S_MA_WR;
            end
            S_MA_WR: begin
                mem_we = 1'b1;
                mem_waddr = r_x.prv;
                mem_wdata = q;
                if (r_xi == r_tail) begin
                    mem_wdata.nxt = r_x.prv;
                    n_tail = r_x.prv;
                    n_state = S_MC_RD;
                end else begin
                    mem_wdata.nxt = r_x.nxt;
                    n_state = S_MB_RD;
                end
            end
            S_MB_RD: begin
                mem_re = 1'b1;
                mem_raddr = r_x.nxt;
                n_state = S_MB_WR;
            end
            S_MB_WR: begin
                mem_we = 1'b1;
                mem_waddr = r_x.nxt;
                mem_wdata = q;
                mem_wdata.prv = r_x.prv;
                n_state = S_MC_RD;
            end
            S_MC_RD: begin
                mem_re = 1'b1;
                mem_raddr = r_head;
                n_state = S_MC_WR;
            end
            S_MC_WR: begin
                mem_we = 1'b1;
                mem_waddr = r_head;
                mem_wdata = q;
                mem_wdata.prv = r_xi;
                n_x.nxt = r_head;
                n_x.prv = r_xi;
                n_head = r_xi;
                n_state = S_WX;
            end
            S_WX: begin
                mem_we = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_ovalid || i_m_tready) begin
                    n_out = r_res;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ci     <= '0;
            r_head   <= LAST;
            r_tail   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ci     <= n_ci;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_ok <= n_ok; r_dev <= n_dev; r_blk <= n_blk;
        r_v <= n_v; r_xi <= n_xi; r_x <= n_x; r_move <= n_move;
        r_res <= n_res; r_out <= n_out;
    end

    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head != r_tail) else $error("recency head and tail collapsed");
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_state != S_IDLE) else $error("memory write while idle");
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_OUT) else $error("stray result");
    a_move_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MC_WR |=> r_head == $past(r_xi)) else $error("head not updated");
endmodule
